// File: hw/rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the ring buffer deque
// Opcodes, status codes, controller states and the command/status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int ELEM_WIDTH_DEFAULT = 32;

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_INSERT     = 3'd5,
        OP_REMOVE     = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_INS_RD,
        S_INS_WR,
        S_REM_CAP,
        S_REM_RD,
        S_REM_WR,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        WA_TAIL,
        WA_HEAD_PREV,
        WA_CUR
    } wr_addr_t;

    typedef enum logic [2:0] {
        RA_HEAD,
        RA_TAIL_PREV,
        RA_SLOT,
        RA_CUR_PREV,
        RA_CUR_NEXT
    } rd_addr_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_TAIL,
        CUR_SLOT,
        CUR_PREV,
        CUR_NEXT
    } cur_sel_t;

    typedef struct packed {
        logic     load_req;
        logic     set_status;
        status_t  status_val;
        logic     wr_en;
        wr_addr_t wr_addr;
        logic     wr_from_ram;
        logic     rd_en;
        rd_addr_t rd_addr;
        logic     head_inc;
        logic     head_dec;
        logic     tail_inc;
        logic     tail_dec;
        cur_sel_t cur_sel;
        logic     cap_rdata;
        logic     load_rsp;
    } rbd_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    pos_bad;
        logic    cur_at_slot;
        logic    cur_next_tail;
        logic    rsp_free;
    } rbd_stat_t;

endpackage

// File: hw/rtl/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter  int WIDTH  = rbd_pkg::ELEM_WIDTH_DEFAULT,
    parameter  int DEPTH  = rbd_pkg::DEPTH_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath: pointers, ring store and result register
// Holds head, tail and shift cursor, the request and result registers,
// and derives length, full/empty and the physical slot of a position.
// ----------------------------------------------------------------------------
module rbd_datapath #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
    parameter int ELEM_WIDTH = rbd_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbd_pkg::rbd_cmd_t             cmd,
    output rbd_pkg::rbd_stat_t            stat,
    input  logic [rbd_pkg::OPCODE_W-1:0]  opcode,
    input  logic [rbd_pkg::DATA_W-1:0]    elem_data,
    input  logic [rbd_pkg::POS_W-1:0]     position,
    input  logic                          rsp_stall,
    output logic                          rsp_valid,
    output logic [rbd_pkg::DATA_W-1:0]    read_data,
    output logic [rbd_pkg::STATUS_W-1:0]  status,
    output logic [rbd_pkg::COUNT_W-1:0]   entry_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CMP_W = (PTR_W > rbd_pkg::POS_W) ? PTR_W : rbd_pkg::POS_W;
    localparam int SUM_W = CMP_W + 1;
    localparam logic [PTR_W-1:0] LAST      = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic             rsp_valid_reg, rsp_valid_next;

    rbd_pkg::opcode_t             op_reg, op_next;
    logic [ELEM_WIDTH-1:0]        data_reg, data_next;
    logic [rbd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0]        rdata_reg, rdata_next;
    rbd_pkg::status_t             status_reg, status_next;
    logic [rbd_pkg::DATA_W-1:0]   rsp_data_reg, rsp_data_next;
    logic [rbd_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [rbd_pkg::COUNT_W-1:0]  rsp_count_reg, rsp_count_next;

    logic [PTR_W-1:0]      len;
    logic [CMP_W-1:0]      len_cmp;
    logic [SUM_W-1:0]      slot_sum;
    logic [PTR_W-1:0]      slot;
    logic [PTR_W-1:0]      ram_wr_addr;
    logic [PTR_W-1:0]      ram_rd_addr;
    logic [ELEM_WIDTH-1:0] ram_wr_data;
    logic [ELEM_WIDTH-1:0] ram_rd_data;

    // Length, and the physical slot of a logical position (valid when in range)
    assign len      = (tail_reg >= head_reg) ? tail_reg - head_reg
                    : PTR_W'({1'b0, tail_reg} + DEPTH_EXT - {1'b0, head_reg});
    assign len_cmp  = CMP_W'(len);
    assign slot_sum = SUM_W'(head_reg) + SUM_W'(pos_reg);
    assign slot     = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM)
                                              : PTR_W'(slot_sum);

    assign stat.op            = op_reg;
    assign stat.full          = (ptr_next(tail_reg) == head_reg);
    assign stat.empty         = (head_reg == tail_reg);
    assign stat.pos_bad       = (CMP_W'(pos_reg) >= len_cmp);
    assign stat.cur_at_slot   = (cur_reg == slot);
    assign stat.cur_next_tail = (ptr_next(cur_reg) == tail_reg);
    assign stat.rsp_free      = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        unique case (cmd.wr_addr)
            rbd_pkg::WA_TAIL:      ram_wr_addr = tail_reg;
            rbd_pkg::WA_HEAD_PREV: ram_wr_addr = ptr_prev(head_reg);
            rbd_pkg::WA_CUR:       ram_wr_addr = cur_reg;
            default:               ram_wr_addr = tail_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_addr)
            rbd_pkg::RA_HEAD:      ram_rd_addr = head_reg;
            rbd_pkg::RA_TAIL_PREV: ram_rd_addr = ptr_prev(tail_reg);
            rbd_pkg::RA_SLOT:      ram_rd_addr = slot;
            rbd_pkg::RA_CUR_PREV:  ram_rd_addr = ptr_prev(cur_reg);
            rbd_pkg::RA_CUR_NEXT:  ram_rd_addr = ptr_next(cur_reg);
            default:               ram_rd_addr = head_reg;
        endcase
    end

    assign ram_wr_data = cmd.wr_from_ram ? ram_rd_data : data_reg;

    rbd_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_inc)
        begin
            head_next = ptr_next(head_reg);
        end
        else if (cmd.head_dec)
        begin
            head_next = ptr_prev(head_reg);
        end

        tail_next = tail_reg;
        if (cmd.tail_inc)
        begin
            tail_next = ptr_next(tail_reg);
        end
        else if (cmd.tail_dec)
        begin
            tail_next = ptr_prev(tail_reg);
        end

        unique case (cmd.cur_sel)
            rbd_pkg::CUR_HOLD: cur_next = cur_reg;
            rbd_pkg::CUR_TAIL: cur_next = tail_reg;
            rbd_pkg::CUR_SLOT: cur_next = slot;
            rbd_pkg::CUR_PREV: cur_next = ptr_prev(cur_reg);
            rbd_pkg::CUR_NEXT: cur_next = ptr_next(cur_reg);
            default:           cur_next = cur_reg;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        data_next = data_reg;
        pos_next  = pos_reg;
        if (cmd.load_req)
        begin
            op_next   = rbd_pkg::opcode_t'(opcode);
            data_next = ELEM_WIDTH'(elem_data);
            pos_next  = position;
        end

        status_next = status_reg;
        rdata_next  = rdata_reg;
        if (cmd.set_status)
        begin
            status_next = cmd.status_val;
            rdata_next  = '0;
        end
        if (cmd.cap_rdata)
        begin
            rdata_next = ram_rd_data;
        end
    end

    // Result register: free once taken, so a finished result can wait here
    always_comb
    begin
        rsp_data_next   = rsp_data_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        if (cmd.load_rsp)
        begin
            rsp_valid_next  = 1'b1;
            rsp_data_next   = rbd_pkg::DATA_W'(rdata_reg);
            rsp_status_next = status_reg;
            rsp_count_next  = rbd_pkg::COUNT_W'(len_cmp);
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        data_reg       <= data_next;
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        rdata_reg      <= rdata_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_data   = rsp_data_reg;
    assign status      = rsp_status_reg;
    assign entry_count = rsp_count_reg;

endmodule

// File: hw/rtl/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl: operation sequencer for the ring buffer deque
// Decodes the latched opcode, drives RAM and pointer commands, walks the
// shift loops of insert and remove, and hands the result to the output.
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rbd_pkg::rbd_stat_t stat,
    output rbd_pkg::rbd_cmd_t  cmd
);

    rbd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_stall  = (state_reg != rbd_pkg::S_IDLE);

        unique case (state_reg)
            rbd_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = rbd_pkg::S_EXEC;
                end
            end

            rbd_pkg::S_EXEC:
            begin
                cmd.set_status = 1'b1;
                cmd.status_val = rbd_pkg::ST_OK;
                state_next     = rbd_pkg::S_RESULT;
                unique case (stat.op)
                    rbd_pkg::OP_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_val = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_addr  = rbd_pkg::WA_TAIL;
                            cmd.tail_inc = 1'b1;
                        end
                    end
                    rbd_pkg::OP_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_val = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_addr  = rbd_pkg::WA_HEAD_PREV;
                            cmd.head_dec = 1'b1;
                        end
                    end
                    rbd_pkg::OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_val = rbd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_addr  = rbd_pkg::RA_HEAD;
                            cmd.head_inc = 1'b1;
                            state_next   = rbd_pkg::S_RD_WAIT;
                        end
                    end
                    rbd_pkg::OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_val = rbd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_addr  = rbd_pkg::RA_TAIL_PREV;
                            cmd.tail_dec = 1'b1;
                            state_next   = rbd_pkg::S_RD_WAIT;
                        end
                    end
                    rbd_pkg::OP_READ:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.status_val = rbd_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = rbd_pkg::RA_SLOT;
                            state_next  = rbd_pkg::S_RD_WAIT;
                        end
                    end
                    rbd_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_val = rbd_pkg::ST_FULL;
                        end
                        else if (stat.pos_bad)
                        begin
                            // position at or past the length: append
                            cmd.wr_en    = 1'b1;
                            cmd.wr_addr  = rbd_pkg::WA_TAIL;
                            cmd.tail_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.cur_sel = rbd_pkg::CUR_TAIL;
                            state_next  = rbd_pkg::S_INS_RD;
                        end
                    end
                    rbd_pkg::OP_REMOVE:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.status_val = rbd_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = rbd_pkg::RA_SLOT;
                            cmd.cur_sel = rbd_pkg::CUR_SLOT;
                            state_next  = rbd_pkg::S_REM_CAP;
                        end
                    end
                    default:
                    begin
                        // unused opcode: report ok, change nothing
                    end
                endcase
            end

            rbd_pkg::S_RD_WAIT:
            begin
                cmd.cap_rdata = 1'b1;
                state_next    = rbd_pkg::S_RESULT;
            end

            // Insert: walk the cursor from tail down to the insert slot
            rbd_pkg::S_INS_RD:
            begin
                if (stat.cur_at_slot)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_addr  = rbd_pkg::WA_CUR;
                    cmd.tail_inc = 1'b1;
                    state_next   = rbd_pkg::S_RESULT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = rbd_pkg::RA_CUR_PREV;
                    state_next  = rbd_pkg::S_INS_WR;
                end
            end

            rbd_pkg::S_INS_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr     = rbd_pkg::WA_CUR;
                cmd.wr_from_ram = 1'b1;
                cmd.cur_sel     = rbd_pkg::CUR_PREV;
                state_next      = rbd_pkg::S_INS_RD;
            end

            rbd_pkg::S_REM_CAP:
            begin
                cmd.cap_rdata = 1'b1;
                state_next    = rbd_pkg::S_REM_RD;
            end

            // Remove: pull each later entry down one slot until the tail
            rbd_pkg::S_REM_RD:
            begin
                if (stat.cur_next_tail)
                begin
                    cmd.tail_dec = 1'b1;
                    state_next   = rbd_pkg::S_RESULT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = rbd_pkg::RA_CUR_NEXT;
                    state_next  = rbd_pkg::S_REM_WR;
                end
            end

            rbd_pkg::S_REM_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr     = rbd_pkg::WA_CUR;
                cmd.wr_from_ram = 1'b1;
                cmd.cur_sel     = rbd_pkg::CUR_NEXT;
                state_next      = rbd_pkg::S_REM_RD;
            end

            rbd_pkg::S_RESULT:
            begin
                // hold until the result register is free
                if (stat.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = rbd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rbd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a ring store
// Push/pop at both ends, read, insert and remove at a logical position,
// each answered with data, status and the element count.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, elem_data, position
//   rsp      out        rsp_valid / rsp_stall  read_data, status, entry_count
//
// One request is worked at a time; insert and remove take longer as more
// entries are shifted. A finished result waits in the output register while
// the next request is taken; a second finished result holds req_stall high
// until the first is taken. Reset clears head, tail and control; the store
// keeps no reset.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
    parameter int ELEM_WIDTH = rbd_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [rbd_pkg::OPCODE_W-1:0]  opcode,
    input  logic [rbd_pkg::DATA_W-1:0]    elem_data,
    input  logic [rbd_pkg::POS_W-1:0]     position,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [rbd_pkg::DATA_W-1:0]    read_data,
    output logic [rbd_pkg::STATUS_W-1:0]  status,
    output logic [rbd_pkg::COUNT_W-1:0]   entry_count
);

    rbd_pkg::rbd_cmd_t  cmd;
    rbd_pkg::rbd_stat_t stat;

    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rbd_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .elem_data   (elem_data),
        .position    (position),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// File: hw/rtl/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker: port-level assertions for the ring buffer deque
// Checks request and result holding under stall, the data of refused
// results, and the consistency of empty and full results with the reported count.
// ----------------------------------------------------------------------------
module rbd_checker #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic [rbd_pkg::OPCODE_W-1:0]  opcode,
    input logic [rbd_pkg::DATA_W-1:0]    elem_data,
    input logic [rbd_pkg::POS_W-1:0]     position,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [rbd_pkg::DATA_W-1:0]    read_data,
    input logic [rbd_pkg::STATUS_W-1:0]  status,
    input logic [rbd_pkg::COUNT_W-1:0]   entry_count
);

    localparam logic [rbd_pkg::COUNT_W-1:0] FULL_COUNT = rbd_pkg::COUNT_W'(DEPTH - 1);

    // a stalled request transaction holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(opcode)
                                   && $stable(elem_data) && $stable(position))
        else $error("request changed while stalled");

    // a stalled result transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data)
                                   && $stable(status) && $stable(entry_count))
        else $error("result changed while stalled");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != rbd_pkg::ST_OK) |-> read_data == '0)
        else $error("refused operation returned data");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == rbd_pkg::ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == rbd_pkg::ST_FULL) |-> entry_count == FULL_COUNT)
        else $error("full status without full count");

endmodule

bind ring_buffer_deque rbd_checker #(
    .DEPTH (DEPTH)
) u_rbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .elem_data   (elem_data),
    .position    (position),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_data   (read_data),
    .status      (status),
    .entry_count (entry_count)
);

// File: tb/sv/tb_ring_buffer_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque: self-checking bench for the ring buffer deque
// Drives directed corner transactions and then biased random fill/drain
// sequences through the request channel, tracks the deque contents in a
// local shadow and compares every response field by field. The sender
// idles in bursts and the receiver stalls on its own pattern, with long
// hold-offs and full drains mixed in.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque;

    localparam logic [rbd_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int NUM_RANDOM = 1250;
    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_LEN   = 300;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct {
        logic [rbd_pkg::OPCODE_W-1:0] opcode;
        logic [rbd_pkg::DATA_W-1:0]   elem_data;
        logic [rbd_pkg::POS_W-1:0]    position;
        bit                           drain;
    } deque_op_t;

    typedef struct {
        logic [rbd_pkg::DATA_W-1:0]  read_data;
        rbd_pkg::status_t            status;
        logic [rbd_pkg::COUNT_W-1:0] entry_count;
    } deque_rsp_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         req_valid   = 1'b0;
    logic                         req_stall;
    logic [rbd_pkg::OPCODE_W-1:0] opcode      = '0;
    logic [rbd_pkg::DATA_W-1:0]   elem_data   = '0;
    logic [rbd_pkg::POS_W-1:0]    position    = '0;
    logic                         rsp_valid;
    logic                         rsp_stall   = 1'b0;
    logic [rbd_pkg::DATA_W-1:0]   read_data;
    logic [rbd_pkg::STATUS_W-1:0] status;
    logic [rbd_pkg::COUNT_W-1:0]  entry_count;

    // shadow of the deque contents
    logic [rbd_pkg::DATA_W-1:0] ring_mem [rbd_pkg::DEPTH_DEFAULT];
    logic [rbd_pkg::POS_W-1:0]  ring_head = '0;
    logic [rbd_pkg::POS_W-1:0]  ring_tail = '0;

    deque_op_t  op_queue[$];
    deque_rsp_t rsp_queue[$];

    int  fail_count  = 0;
    int  reqs_taken  = 0;
    int  idle_cycles = 0;
    bit  req_fire    = 1'b0;
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  stall_mode  = 0;
    int  mode_left   = 0;
    int  stall_tick  = 0;
    int  hold_left   = 0;
    int  holds_done  = 0;

    ring_buffer_deque i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .elem_data   (elem_data),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count)
    );

    always #1 clk = ~clk;

    // Apply one operation to the shadow deque and return its response.
    function automatic deque_rsp_t deque_exec(input deque_op_t t);
        deque_rsp_t                r;
        logic [rbd_pkg::POS_W-1:0] len;
        logic [rbd_pkg::POS_W-1:0] nxt_tail;
        logic [rbd_pkg::POS_W-1:0] at;
        logic [rbd_pkg::POS_W-1:0] idx;
        logic [rbd_pkg::POS_W-1:0] nb;
        r.read_data = '0;
        r.status    = rbd_pkg::ST_OK;
        len         = ring_tail - ring_head;
        nxt_tail    = ring_tail + 1'b1;
        at          = ring_head + t.position;
        case (t.opcode)
            rbd_pkg::OP_PUSH_BACK:
                if (nxt_tail == ring_head)
                    r.status = rbd_pkg::ST_FULL;
                else
                begin
                    ring_mem[ring_tail] = t.elem_data;
                    ring_tail = nxt_tail;
                end
            rbd_pkg::OP_PUSH_FRONT:
                if (nxt_tail == ring_head)
                    r.status = rbd_pkg::ST_FULL;
                else
                begin
                    ring_head = ring_head - 1'b1;
                    ring_mem[ring_head] = t.elem_data;
                end
            rbd_pkg::OP_POP_FRONT:
                if (len == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                begin
                    r.read_data = ring_mem[ring_head];
                    ring_head = ring_head + 1'b1;
                end
            rbd_pkg::OP_POP_BACK:
                if (len == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                begin
                    ring_tail = ring_tail - 1'b1;
                    r.read_data = ring_mem[ring_tail];
                end
            rbd_pkg::OP_READ:
                if (t.position >= len)
                    r.status = rbd_pkg::ST_BAD_INDEX;
                else
                    r.read_data = ring_mem[at];
            rbd_pkg::OP_INSERT:
                if (nxt_tail == ring_head)
                    r.status = rbd_pkg::ST_FULL;
                else if (t.position >= len)
                begin
                    ring_mem[ring_tail] = t.elem_data;
                    ring_tail = nxt_tail;
                end
                else
                begin
                    // shift the upper part one slot toward the tail
                    idx = ring_tail;
                    while (idx != at)
                    begin
                        nb = idx - 1'b1;
                        ring_mem[idx] = ring_mem[nb];
                        idx = nb;
                    end
                    ring_mem[at] = t.elem_data;
                    ring_tail = nxt_tail;
                end
            rbd_pkg::OP_REMOVE:
                if (t.position >= len)
                    r.status = rbd_pkg::ST_BAD_INDEX;
                else
                begin
                    idx = at;
                    r.read_data = ring_mem[idx];
                    nb = idx + 1'b1;
                    while (nb != ring_tail)
                    begin
                        ring_mem[idx] = ring_mem[nb];
                        idx = nb;
                        nb = idx + 1'b1;
                    end
                    ring_tail = ring_tail - 1'b1;
                end
            default:
                ;
        endcase
        r.entry_count = ring_tail - ring_head;
        return r;
    endfunction

    task automatic add_op(input logic [rbd_pkg::OPCODE_W-1:0] op,
                          input logic [rbd_pkg::DATA_W-1:0] data,
                          input logic [rbd_pkg::POS_W-1:0] pos);
        deque_op_t t;
        t.opcode    = op;
        t.elem_data = data;
        t.position  = pos;
        t.drain     = 1'b0;
        op_queue.push_back(t);
    endtask

    task automatic add_drain();
        deque_op_t t;
        t.opcode    = OP_UNUSED;
        t.elem_data = '0;
        t.position  = '0;
        t.drain     = 1'b1;
        op_queue.push_back(t);
    endtask

    function automatic logic [rbd_pkg::DATA_W-1:0] rand_data();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    // Request driver: advance on acceptance, otherwise hold the payload.
    always @(negedge clk)
    begin : req_drive
        deque_op_t t;
        logic      offer;
        offer = 1'b0;
        if (rst_n && (!req_valid || req_fire))
        begin
            if (gap_left != 0)
                gap_left--;
            else if (op_queue.size() != 0)
            begin
                if (op_queue[0].drain)
                begin
                    if (rsp_queue.size() == 0)
                        t = op_queue.pop_front();
                end
                else
                begin
                    t = op_queue.pop_front();
                    offer = 1'b1;
                    opcode    <= t.opcode;
                    elem_data <= t.elem_data;
                    position  <= t.position;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            req_valid <= offer;
        end
    end

    // Response stall: long hold-offs at fixed points, otherwise a changing pattern.
    always @(negedge clk)
    begin : rsp_stall_gen
        logic stall_nxt;
        stall_tick++;
        if (hold_left == 0 && holds_done < 2 && reqs_taken >= 300 + 500 * holds_done)
        begin
            hold_left = HOLD_LEN;
            holds_done++;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(64, 256);
        end
        else
            mode_left--;
        if (hold_left != 0)
        begin
            stall_nxt = 1'b1;
            hold_left--;
        end
        else
            case (stall_mode)
                0:       stall_nxt = 1'b0;
                1:       stall_nxt = ($urandom_range(0, 3) == 0);
                2:       stall_nxt = ($urandom_range(0, 3) != 0);
                default: stall_nxt = stall_tick[1];
            endcase
        rsp_stall <= stall_nxt;
    end

    // Check responses first, then record the request accepted at this edge.
    always @(posedge clk)
    begin : rsp_check
        deque_rsp_t e;
        deque_op_t  t;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("response with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    e = rsp_queue.pop_front();
                    if (read_data !== e.read_data)
                    begin
                        $error("read_data: expected %h, got %h", e.read_data, read_data);
                        fail_count++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        fail_count++;
                    end
                    if (entry_count !== e.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                t.opcode    = opcode;
                t.elem_data = elem_data;
                t.position  = position;
                t.drain     = 1'b0;
                rsp_queue.push_back(deque_exec(t));
                reqs_taken++;
            end
        end
        req_fire <= rst_n && req_valid && !req_stall;
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        mix_t                         mix;
        int                           pick;
        int                           push_lim;
        int                           ins_lim;
        int                           rd_lim;
        int                           pop_lim;
        logic [rbd_pkg::OPCODE_W-1:0] op;
        logic [rbd_pkg::POS_W-1:0]    pos;

        // empty deque corners and the unused opcode
        add_op(rbd_pkg::OP_POP_FRONT, '1, '0);
        add_op(rbd_pkg::OP_POP_BACK, '1, '1);
        add_op(rbd_pkg::OP_READ, '0, '0);
        add_op(rbd_pkg::OP_REMOVE, '0, '0);
        add_op(OP_UNUSED, '1, '1);
        // fill to capacity through every way in
        add_op(rbd_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, '0);
        add_op(rbd_pkg::OP_PUSH_FRONT, 32'h0000_0000, '0);
        add_op(rbd_pkg::OP_INSERT, 32'hAAAA_AAAA, 4'd0);
        add_op(rbd_pkg::OP_INSERT, 32'h5555_5555, 4'd15);
        add_op(rbd_pkg::OP_INSERT, 32'h1234_5678, 4'd2);
        for (int k = 0; k < 10; k++)
            add_op((k % 2) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK, rand_data(), '0);
        // refused while full, then reads at and past the end and one remove
        add_op(rbd_pkg::OP_PUSH_BACK, rand_data(), '0);
        add_op(rbd_pkg::OP_PUSH_FRONT, rand_data(), '0);
        add_op(rbd_pkg::OP_INSERT, rand_data(), 4'd3);
        add_op(rbd_pkg::OP_READ, '0, 4'd14);
        add_op(rbd_pkg::OP_READ, '0, 4'd15);
        add_op(rbd_pkg::OP_REMOVE, '0, 4'd7);
        add_drain();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 50 == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                case (mix)
                    MIX_FILL:
                    begin
                        push_lim = 45; ins_lim = 70; rd_lim = 80; pop_lim = 90;
                    end
                    MIX_DRAIN:
                    begin
                        push_lim = 15; ins_lim = 25; rd_lim = 40; pop_lim = 80;
                    end
                    default:
                    begin
                        push_lim = 30; ins_lim = 45; rd_lim = 65; pop_lim = 85;
                    end
                endcase
            end
            if (n == 400 || n == 1000)
                add_drain();
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = OP_UNUSED;
            else if (pick < push_lim)
                op = $urandom_range(0, 1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK;
            else if (pick < ins_lim)
                op = rbd_pkg::OP_INSERT;
            else if (pick < rd_lim)
                op = rbd_pkg::OP_READ;
            else if (pick < pop_lim)
                op = $urandom_range(0, 1) ? rbd_pkg::OP_POP_BACK : rbd_pkg::OP_POP_FRONT;
            else
                op = rbd_pkg::OP_REMOVE;
            pos = $urandom_range(0, 1) ? rbd_pkg::POS_W'($urandom_range(0, 15))
                                       : rbd_pkg::POS_W'($urandom_range(0, 7));
            add_op(op, rand_data(), pos);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || req_valid || rsp_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (rsp_queue.size() != 0)
        begin
            $error("%0d responses never arrived", rsp_queue.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
